// ===== rtl/core/vlr_pkg.sv =====
// Shared types, codes and constants of the video line renderer.
`timescale 1ns / 1ps
package vlr_pkg;

  localparam int LINE_PIXELS    = 704;
  localparam int FRAME_LINES    = 240;
  localparam int SPRITE_COUNT   = 64;

  localparam int ACTIVE_FIRST   = 16;
  localparam int ACTIVE_END     = 216;
  localparam int TEXT_X_OFFSET  = 32;
  localparam int ACTIVE_WIDTH   = 640;
  localparam int TEXT_COLS_40   = 40;
  localparam int TEXT_COLS_80   = 80;
  localparam int BORDER_CHAR_40 = 'h3FF;
  localparam int BORDER_CHAR_80 = 'h7FF;
  localparam int BM_COLOR_BASE  = 'h2000;
  localparam int BM_PIXELS      = 320;
  localparam int TILES_PER_LINE = 41;
  localparam int GFX_LINE_DEPTH = 512;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;

  localparam logic [3:0] MEM_SCREEN   = 4'd0;
  localparam logic [3:0] MEM_COLOR    = 4'd1;
  localparam logic [3:0] MEM_CHAR     = 4'd2;
  localparam logic [3:0] MEM_VIDEO    = 4'd3;
  localparam logic [3:0] MEM_PALETTE  = 4'd4;
  localparam logic [3:0] MEM_SPR_X    = 4'd5;
  localparam logic [3:0] MEM_SPR_Y    = 4'd6;
  localparam logic [3:0] MEM_SPR_TILE = 4'd7;
  localparam logic [3:0] MEM_SPR_ATTR = 4'd8;

  localparam logic [1:0] GFX_NONE = 2'd0;
  localparam logic [1:0] GFX_BM1  = 2'd1;
  localparam logic [1:0] GFX_TILE = 2'd2;
  localparam logic [1:0] GFX_BM4  = 2'd3;

  localparam logic [2:0] REG_GFX_MODE      = 3'd0;
  localparam logic [2:0] REG_TEXT_ENABLE   = 3'd1;
  localparam logic [2:0] REG_TEXT_OVER_GFX = 3'd2;
  localparam logic [2:0] REG_EIGHTY_COLS   = 3'd3;
  localparam logic [2:0] REG_REMAP_BORDER  = 3'd4;
  localparam logic [2:0] REG_SPRITE_ENABLE = 3'd5;
  localparam logic [2:0] REG_SCROLL_X      = 3'd6;
  localparam logic [2:0] REG_SCROLL_Y      = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PX_A,
    ST_PX_B,
    ST_PX_C,
    ST_PX_OUT,
    ST_BM_RD1,
    ST_BM_RD2,
    ST_BM_WR,
    ST_TL_LO,
    ST_TL_HI,
    ST_TL_ATT,
    ST_TL_RD,
    ST_TL_WR,
    ST_SP_RD,
    ST_SP_CHK,
    ST_SP_PRD,
    ST_SP_PWR
  } vlr_state_t;

  typedef struct packed {
    logic [1:0] gfx_mode;
    logic       text_enable;
    logic       text_over_gfx;
    logic       eighty_columns;
    logic       remap_border;
    logic       sprite_enable;
    logic [8:0] scroll_x;
    logic [7:0] scroll_y;
  } vlr_cfg_t;

  typedef struct packed {
    logic       accept;
    vlr_state_t phase;
  } vlr_cmd_t;

  typedef struct packed {
    logic px_go;
    logic build_go;
    logic tile_mode;
    logic spr_en;
    logic out_free;
    logic bm_last;
    logic tl_px_last;
    logic tl_last;
    logic sp_hit;
    logic sp_last;
    logic sp_px_last;
  } vlr_status_t;

endpackage

// ===== rtl/core/vlr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vlr_ctrl.sv =====
// Sequencer of the renderer: pixel lookup, line build and sprite passes.
`timescale 1ns / 1ps
module vlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  vlr_pkg::vlr_status_t status,
  output logic                s_tready,
  output vlr_pkg::vlr_cmd_t   cmd
);
  import vlr_pkg::*;

  vlr_state_t state, state_next;
  vlr_state_t after_gfx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    after_gfx  = status.spr_en ? ST_SP_RD : ST_IDLE;
    s_tready   = (state == ST_IDLE);
    cmd.accept = s_tvalid && s_tready;
    cmd.phase  = state;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (status.px_go) begin
            state_next = ST_PX_A;
          end else if (status.build_go) begin
            state_next = status.tile_mode ? ST_TL_LO : ST_BM_RD1;
          end
        end
      end
      ST_PX_A:   state_next = ST_PX_B;
      ST_PX_B:   state_next = ST_PX_C;
      ST_PX_C:   state_next = ST_PX_OUT;
      ST_PX_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BM_RD1: state_next = ST_BM_RD2;
      ST_BM_RD2: state_next = ST_BM_WR;
      ST_BM_WR:  state_next = status.bm_last ? after_gfx : ST_BM_RD1;
      ST_TL_LO:  state_next = ST_TL_HI;
      ST_TL_HI:  state_next = ST_TL_ATT;
      ST_TL_ATT: state_next = ST_TL_RD;
      ST_TL_RD:  state_next = ST_TL_WR;
      ST_TL_WR: begin
        if (!status.tl_px_last) begin
          state_next = ST_TL_RD;
        end else begin
          state_next = status.tl_last ? after_gfx : ST_TL_LO;
        end
      end
      ST_SP_RD:  state_next = ST_SP_CHK;
      ST_SP_CHK: begin
        if (status.sp_hit) begin
          state_next = ST_SP_PRD;
        end else begin
          state_next = status.sp_last ? ST_IDLE : ST_SP_RD;
        end
      end
      ST_SP_PRD: state_next = ST_SP_PWR;
      ST_SP_PWR: begin
        if (!status.sp_px_last) begin
          state_next = ST_SP_PRD;
        end else begin
          state_next = status.sp_last ? ST_IDLE : ST_SP_RD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/vlr_datapath.sv =====
// Memories, line buffer build datapath and pixel composition.
`timescale 1ns / 1ps
module vlr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  vlr_pkg::vlr_cmd_t    cmd,
  input  vlr_pkg::vlr_cfg_t    cfg,
  input  logic [1:0]           req_type,
  input  logic [3:0]           mem_select,
  input  logic [13:0]          mem_addr,
  input  logic [15:0]          mem_data,
  input  logic [8:0]           line_number,
  input  logic [9:0]           pixel_x,
  input  logic                 m_tready,
  output vlr_pkg::vlr_status_t status,
  output logic                 m_tvalid,
  output logic [15:0]          pixel_color
);
  import vlr_pkg::*;

  // item decode
  logic        wr, lo_ok, small_ok;
  logic        we_screen, we_color, we_char, we_video, we_pal;
  logic        we_xpos, we_ypos, we_tile, we_flags;
  logic        ln_in_frame, ln_active;

  // line and pixel state
  logic [8:0]  cur_line;
  logic        in_frame;
  logic [9:0]  px_x;
  logic [7:0]  bm;

  // memory read data
  logic [7:0]  screen_rdata, color_rdata, char_rdata, vram_rdata;
  logic [15:0] pal_rdata;
  logic [8:0]  xpos_rdata, tile_rdata;
  logic [7:0]  ypos_rdata, flags_rdata;
  logic [6:0]  gfx_rdata;
  logic [13:0] vram_raddr;
  logic [8:0]  gfx_raddr, gfx_waddr;
  logic [6:0]  gfx_wdata;
  logic        gfx_we;

  // bitmap sweep
  logic [8:0]  bm_i;
  logic [7:0]  bm_c;
  logic [13:0] bm_a1c, bm_a1b, bm_a3;
  logic [3:0]  bm_v1;
  logic [6:0]  bm_pix;
  logic        bm_in;

  // tilemap
  logic [5:0]  t_cnt, t_col;
  logic [2:0]  t_p, t_q;
  logic [8:0]  t_idx;
  logic [7:0]  t_lo, t_hi, tl;
  logic [3:0]  t_v4;
  logic [6:0]  t_pix;
  logic [13:0] t_lo_addr, t_hi_addr, t_rd_addr;

  // sprites
  logic [SPRITE_COUNT-1:0] fvalid;
  logic        sp_fv;
  logic [5:0]  sp_cnt;
  logic [2:0]  sp_p, s_q, s_row;
  logic [7:0]  sp_f, sp_sl;
  logic [3:0]  sp_sl2, s_v4;
  logic        sp_hit, s_prio, s_hf, s_we;
  logic [1:0]  s_pal;
  logic [8:0]  s_tile, s_idx;

  // text and composition
  logic        vact, act;
  logic [9:0]  pos;
  logic [10:0] taddr;
  logic [2:0]  tpix;
  logic [3:0]  txt;
  logic [5:0]  pal_c;

  assign wr        = cmd.accept && (req_type == REQ_WRITE);
  assign lo_ok     = (mem_addr[13:11] == 3'd0);
  assign small_ok  = (mem_addr[13:6] == 8'd0);
  assign we_screen = wr && (mem_select == MEM_SCREEN) && lo_ok;
  assign we_color  = wr && (mem_select == MEM_COLOR) && lo_ok;
  assign we_char   = wr && (mem_select == MEM_CHAR) && lo_ok;
  assign we_video  = wr && (mem_select == MEM_VIDEO);
  assign we_pal    = wr && (mem_select == MEM_PALETTE) && small_ok;
  assign we_xpos   = wr && (mem_select == MEM_SPR_X) && small_ok;
  assign we_ypos   = wr && (mem_select == MEM_SPR_Y) && small_ok;
  assign we_tile   = wr && (mem_select == MEM_SPR_TILE) && small_ok;
  assign we_flags  = wr && (mem_select == MEM_SPR_ATTR) && small_ok;

  assign ln_in_frame = {1'b0, line_number} < 10'(FRAME_LINES);
  assign ln_active   = (line_number >= 9'(ACTIVE_FIRST)) && (line_number < 9'(ACTIVE_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line <= '0;
      in_frame <= 1'b0;
    end else if (cmd.accept && req_type == REQ_LINE) begin
      cur_line <= line_number;
      in_frame <= ln_in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == REQ_PIXEL) begin
      px_x <= pixel_x;
    end
  end

  assign bm = 8'(cur_line - 9'(ACTIVE_FIRST));

  // sprite attribute valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
    end else if (we_flags) begin
      fvalid[mem_addr[5:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sp_fv <= fvalid[sp_cnt];
  end

  // ---------------- bitmap ----------------
  assign bm_a1c = 14'(14'(BM_COLOR_BASE) + 14'(bm[7:3]) * 14'(TEXT_COLS_40) + 14'(bm_i[8:3]));
  assign bm_a1b = 14'(14'(bm) * 14'(TEXT_COLS_40) + 14'(bm_i[8:3]));
  assign bm_a3  = 14'(14'(bm) * 14'(TEXT_COLS_80) + 14'(bm_i[8:2]));
  assign bm_v1  = vram_rdata[~bm_i[2:0]] ? bm_c[7:4] : bm_c[3:0];
  assign bm_in  = bm_i < 9'(BM_PIXELS);

  always_comb begin
    bm_pix = '0;
    if (bm_in && cfg.gfx_mode == GFX_BM1) begin
      bm_pix = {3'b001, bm_v1};
    end else if (bm_in && cfg.gfx_mode == GFX_BM4) begin
      bm_pix = {3'b001, bm_i[1] ? bm_c[3:0] : bm_c[7:4]};
    end
  end

  // ---------------- tilemap ----------------
  assign tl        = bm + cfg.scroll_y;
  assign t_lo_addr = {2'b00, tl[7:3], t_col, 1'b0};
  assign t_hi_addr = {2'b00, tl[7:3], t_col, 1'b1};
  assign t_q       = t_hi[1] ? ~t_p : t_p;
  assign t_rd_addr = {t_hi[0], t_lo, tl[2:0] ^ {3{t_hi[2]}}, t_q[2:1]};
  assign t_v4      = t_q[0] ? vram_rdata[3:0] : vram_rdata[7:4];
  // blank tile pixels keep the palette bits but not the priority bit
  assign t_pix     = {t_hi[6] & (t_v4 != 4'd0), t_hi[5:4], t_v4};

  // ---------------- sprites ----------------
  assign sp_f   = sp_fv ? flags_rdata : 8'h00;
  assign sp_sl  = bm - ypos_rdata;
  assign sp_hit = sp_f[7] && (sp_f[3] ? (sp_sl < 8'd16) : (sp_sl < 8'd8));
  assign sp_sl2 = sp_sl[3:0] ^ (sp_f[2] ? (sp_f[3] ? 4'hF : 4'h7) : 4'h0);
  assign s_q    = s_hf ? ~sp_p : sp_p;
  assign s_v4   = s_q[0] ? vram_rdata[3:0] : vram_rdata[7:4];
  assign s_we   = (s_prio || !gfx_rdata[6]) && (s_v4 != 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == REQ_LINE) begin
      bm_i   <= '0;
      t_cnt  <= '0;
      t_p    <= '0;
      t_col  <= cfg.scroll_x[8:3];
      t_idx  <= 9'(10'(GFX_LINE_DEPTH) - {7'd0, cfg.scroll_x[2:0]});
      sp_cnt <= '0;
    end
    case (cmd.phase)
      ST_BM_RD2: bm_c <= vram_rdata;
      ST_BM_WR:  bm_i <= bm_i + 9'd1;
      ST_TL_HI:  t_lo <= vram_rdata;
      ST_TL_ATT: t_hi <= vram_rdata;
      ST_TL_WR: begin
        t_idx <= t_idx + 9'd1;
        t_p   <= t_p + 3'd1;
        if (t_p == 3'd7) begin
          t_col <= t_col + 6'd1;
          t_cnt <= t_cnt + 6'd1;
        end
      end
      ST_SP_CHK: begin
        if (sp_hit) begin
          s_tile <= tile_rdata ^ {8'd0, sp_sl2[3]};
          s_row  <= sp_sl2[2:0];
          s_pal  <= sp_f[5:4];
          s_prio <= sp_f[6];
          s_hf   <= sp_f[1];
          s_idx  <= xpos_rdata;
          sp_p   <= '0;
        end else begin
          sp_cnt <= sp_cnt + 6'd1;
        end
      end
      ST_SP_PWR: begin
        s_idx <= s_idx + 9'd1;
        sp_p  <= sp_p + 3'd1;
        if (sp_p == 3'd7) begin
          sp_cnt <= sp_cnt + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      ST_BM_RD1: vram_raddr = (cfg.gfx_mode == GFX_BM4) ? bm_a3 : bm_a1c;
      ST_BM_RD2: vram_raddr = bm_a1b;
      ST_TL_LO:  vram_raddr = t_lo_addr;
      ST_TL_HI:  vram_raddr = t_hi_addr;
      ST_TL_RD:  vram_raddr = t_rd_addr;
      ST_SP_PRD: vram_raddr = {s_tile, s_row, s_q[2:1]};
      default:   vram_raddr = '0;
    endcase
  end

  always_comb begin
    gfx_we    = 1'b0;
    gfx_waddr = bm_i;
    gfx_wdata = bm_pix;
    case (cmd.phase)
      ST_BM_WR: gfx_we = 1'b1;
      ST_TL_WR: begin
        gfx_we    = 1'b1;
        gfx_waddr = t_idx;
        gfx_wdata = t_pix;
      end
      ST_SP_PWR: begin
        gfx_we    = s_we;
        gfx_waddr = s_idx;
        gfx_wdata = {1'b0, s_pal, s_v4};
      end
      default: ;
    endcase
  end

  // ---------------- text layer and composition ----------------
  assign vact = (cur_line >= 9'(ACTIVE_FIRST)) && (cur_line < 9'(ACTIVE_END));
  assign pos  = 10'(px_x - 10'(TEXT_X_OFFSET));
  assign act  = vact && (pos < 10'(ACTIVE_WIDTH));

  always_comb begin
    taddr = '0;
    tpix  = px_x[2:0];
    if (act) begin
      if (cfg.eighty_columns) begin
        taddr = 11'(11'(bm[7:3]) * 11'(TEXT_COLS_80) + 11'(pos[9:3]));
      end else begin
        taddr = 11'(11'(bm[7:3]) * 11'(TEXT_COLS_40) + 11'(pos[9:4]));
        tpix  = px_x[3:1];
      end
    end else if (cfg.remap_border) begin
      taddr = cfg.eighty_columns ? 11'(BORDER_CHAR_80) : 11'(BORDER_CHAR_40);
    end
  end

  assign txt = char_rdata[~tpix] ? color_rdata[7:4] : color_rdata[3:0];
  assign gfx_raddr = (cmd.phase == ST_SP_PRD) ? s_idx : pos[9:1];

  always_comb begin
    pal_c = cfg.text_enable ? {2'b00, txt} : 6'd0;
    if (act) begin
      if (!cfg.text_enable || cfg.text_over_gfx || gfx_rdata[3:0] != 4'd0) begin
        pal_c = gfx_rdata[5:0];
      end
      if (cfg.text_enable && cfg.text_over_gfx && txt != 4'd0) begin
        pal_c = {2'b00, txt};
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.phase == ST_PX_OUT && status.out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == ST_PX_OUT && status.out_free) begin
      pixel_color <= pal_rdata;
    end
  end

  always_comb begin
    status.px_go      = (req_type == REQ_PIXEL) && in_frame &&
                        ({1'b0, pixel_x} < 11'(LINE_PIXELS));
    status.build_go   = (req_type == REQ_LINE) && ln_in_frame && ln_active;
    status.tile_mode  = (cfg.gfx_mode == GFX_TILE);
    status.spr_en     = cfg.sprite_enable;
    status.out_free   = !m_tvalid || m_tready;
    status.bm_last    = (bm_i == 9'(GFX_LINE_DEPTH - 1));
    status.tl_px_last = (t_p == 3'd7);
    status.tl_last    = (t_cnt == 6'(TILES_PER_LINE - 1));
    status.sp_hit     = sp_hit;
    status.sp_last    = (sp_cnt == 6'(SPRITE_COUNT - 1));
    status.sp_px_last = (sp_p == 3'd7);
  end

  // ---------------- memories ----------------
  vlr_ram #(.WIDTH(8), .DEPTH(2048)) u_screen (
    .clk(clk), .we(we_screen), .waddr(mem_addr[10:0]), .wdata(mem_data[7:0]),
    .raddr(taddr), .rdata(screen_rdata));

  vlr_ram #(.WIDTH(8), .DEPTH(2048)) u_color (
    .clk(clk), .we(we_color), .waddr(mem_addr[10:0]), .wdata(mem_data[7:0]),
    .raddr(taddr), .rdata(color_rdata));

  vlr_ram #(.WIDTH(8), .DEPTH(2048)) u_char (
    .clk(clk), .we(we_char), .waddr(mem_addr[10:0]), .wdata(mem_data[7:0]),
    .raddr({screen_rdata, cur_line[2:0]}), .rdata(char_rdata));

  vlr_ram #(.WIDTH(8), .DEPTH(16384)) u_video (
    .clk(clk), .we(we_video), .waddr(mem_addr), .wdata(mem_data[7:0]),
    .raddr(vram_raddr), .rdata(vram_rdata));

  vlr_ram #(.WIDTH(16), .DEPTH(64)) u_palette (
    .clk(clk), .we(we_pal), .waddr(mem_addr[5:0]), .wdata(mem_data),
    .raddr(pal_c), .rdata(pal_rdata));

  vlr_ram #(.WIDTH(9), .DEPTH(64)) u_spr_x (
    .clk(clk), .we(we_xpos), .waddr(mem_addr[5:0]), .wdata(mem_data[8:0]),
    .raddr(sp_cnt), .rdata(xpos_rdata));

  vlr_ram #(.WIDTH(8), .DEPTH(64)) u_spr_y (
    .clk(clk), .we(we_ypos), .waddr(mem_addr[5:0]), .wdata(mem_data[7:0]),
    .raddr(sp_cnt), .rdata(ypos_rdata));

  vlr_ram #(.WIDTH(9), .DEPTH(64)) u_spr_tile (
    .clk(clk), .we(we_tile), .waddr(mem_addr[5:0]), .wdata(mem_data[8:0]),
    .raddr(sp_cnt), .rdata(tile_rdata));

  vlr_ram #(.WIDTH(8), .DEPTH(64)) u_spr_attr (
    .clk(clk), .we(we_flags), .waddr(mem_addr[5:0]), .wdata(mem_data[7:0]),
    .raddr(sp_cnt), .rdata(flags_rdata));

  vlr_ram #(.WIDTH(7), .DEPTH(GFX_LINE_DEPTH)) u_gfx_line (
    .clk(clk), .we(gfx_we), .waddr(gfx_waddr), .wdata(gfx_wdata),
    .raddr(gfx_raddr), .rdata(gfx_rdata));

endmodule

// ===== rtl/core/video_line_renderer_core.sv =====
// Top level of the scanline video renderer: ports, registers, controller, datapath.
//
//  channel  | dir | signals                                   | beat
//  ---------+-----+-------------------------------------------+-----------------------
//  s_axis   | in  | s_tvalid s_tready s_tdata s_tuser         | write / line / pixel
//  m_axis   | out | m_tvalid m_tready m_tdata                 | one palette color
//  apb      | in  | psel penable pwrite paddr pwdata prdata   | register access
//
// A write beat leaves the block idle; a pixel beat passes four steps (screen/color
// read, character, palette, output register). A line start builds the line buffer
// on the single video RAM port: two reads and a write per entry for bitmap or blank
// modes, two map reads then a read and a write per pixel for each tile, then, with
// sprites on, a check per sprite plus a read and a write per pixel of a hit sprite.
// Reset clears the controller, line state, output valid and sprite attribute
// valid bits at once; no clearing pass. A stalled result holds the block in
// its output step; input beats are taken only between items.
`timescale 1ns / 1ps
module video_line_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mem_addr[13:0], mem_data[29:14], line_number[38:30], pixel_x[48:39]
  input  logic [55:0] s_tdata,
  // req_type[1:0], mem_select[5:2]
  input  logic [5:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_color[15:0]
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vlr_pkg::*;

  vlr_cfg_t    cfg;
  vlr_cmd_t    cmd;
  vlr_status_t status;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GFX_MODE:      cfg.gfx_mode       <= pwdata[1:0];
        REG_TEXT_ENABLE:   cfg.text_enable    <= pwdata[0];
        REG_TEXT_OVER_GFX: cfg.text_over_gfx  <= pwdata[0];
        REG_EIGHTY_COLS:   cfg.eighty_columns <= pwdata[0];
        REG_REMAP_BORDER:  cfg.remap_border   <= pwdata[0];
        REG_SPRITE_ENABLE: cfg.sprite_enable  <= pwdata[0];
        REG_SCROLL_X:      cfg.scroll_x       <= pwdata[8:0];
        REG_SCROLL_Y:      cfg.scroll_y       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GFX_MODE:      prdata = {30'd0, cfg.gfx_mode};
      REG_TEXT_ENABLE:   prdata = {31'd0, cfg.text_enable};
      REG_TEXT_OVER_GFX: prdata = {31'd0, cfg.text_over_gfx};
      REG_EIGHTY_COLS:   prdata = {31'd0, cfg.eighty_columns};
      REG_REMAP_BORDER:  prdata = {31'd0, cfg.remap_border};
      REG_SPRITE_ENABLE: prdata = {31'd0, cfg.sprite_enable};
      REG_SCROLL_X:      prdata = {23'd0, cfg.scroll_x};
      REG_SCROLL_Y:      prdata = {24'd0, cfg.scroll_y};
      default:           prdata = '0;
    endcase
  end

  vlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  vlr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .req_type    (s_tuser[1:0]),
    .mem_select  (s_tuser[5:2]),
    .mem_addr    (s_tdata[13:0]),
    .mem_data    (s_tdata[29:14]),
    .line_number (s_tdata[38:30]),
    .pixel_x     (s_tdata[48:39]),
    .m_tready    (m_tready),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .pixel_color (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_px_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.phase == ST_PX_OUT && status.out_free) |=> m_tvalid)
    else $error("pixel result not registered");

  a_px_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.px_go) |=> (cmd.phase == ST_PX_A))
    else $error("pixel beat did not start lookup");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && s_tuser[1:0] == REQ_WRITE) |=> s_tready)
    else $error("memory write beat held the input");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the scanline video renderer: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps
module testbench;
  import vlr_pkg::*;

  class pixel_scoreboard;
    bit [7:0]  screen_ram[2048];
    bit [7:0]  color_ram[2048];
    bit [7:0]  char_ram[2048];
    bit [7:0]  video_ram[16384];
    bit [15:0] palette[64];
    bit [8:0]  spr_x[64];
    bit [7:0]  spr_y[64];
    bit [8:0]  spr_tile[64];
    bit [7:0]  spr_flags[64];
    bit [7:0]  line_buf[512];
    bit [8:0]  cur_line;
    bit        in_frame;
    vlr_cfg_t  cfg;
    bit [15:0] expected_colors[$];
    int        errors;

    function int unsigned vram(int unsigned a);
      return video_ram[a & 'h3FFF];
    endfunction

    function int unsigned pat(int unsigned base, int unsigned q);
      int unsigned d;
      d = vram(base + (q >> 1));
      return q[0] ? (d & 'hF) : (d >> 4);
    endfunction

    function void build_tiles(int unsigned bm);
      int unsigned idx, tl, row, col, lo, hi, tile, attr, base, v;
      idx = (512 - (cfg.scroll_x & 7)) & 511;
      tl = (bm + cfg.scroll_y) & 255;
      row = (tl >> 3) & 31;
      col = (cfg.scroll_x >> 3) & 63;
      for (int t = 0; t < TILES_PER_LINE; t++) begin
        lo = vram((row << 7) | (col << 1));
        hi = vram((row << 7) | (col << 1) | 1);
        tile = ((hi & 1) << 8) | lo;
        attr = hi & 'h70;
        base = (tile << 5) | ((tl & 7) << 2);
        if (hi & 4) base ^= 7 << 2;
        col = (col + 1) & 63;
        for (int p = 0; p < 8; p++) begin
          v = pat(base, (hi & 2) ? 7 - p : p);
          v |= attr & ((v == 0) ? 'h30 : 'h70);
          line_buf[idx] = 8'(v);
          idx = (idx + 1) & 511;
        end
      end
    endfunction

    function void draw_sprites(int unsigned bm);
      int unsigned f, sl, base, idx, pal, v;
      bit h16, prio;
      for (int i = 0; i < SPRITE_COUNT; i++) begin
        f = spr_flags[i];
        h16 = f[3];
        if (!f[7]) continue;
        sl = (bm - spr_y[i]) & 'hFF;
        if (sl >= (h16 ? 16 : 8)) continue;
        if (f[2]) sl ^= h16 ? 15 : 7;
        base = (((spr_tile[i] ^ (sl >> 3)) & 'h1FF) << 5) | ((sl & 7) << 2);
        pal = f & 'h30;
        prio = f[6];
        idx = spr_x[i];
        for (int p = 0; p < 8; p++) begin
          v = pat(base, f[1] ? 7 - p : p);
          if ((prio || !line_buf[idx][6]) && v != 0) line_buf[idx] = 8'(v | pal);
          idx = (idx + 1) & 511;
        end
      end
    endfunction

    function void build_line(int unsigned ln);
      int unsigned bm, c, b;
      bm = ln - ACTIVE_FIRST;
      if (cfg.gfx_mode == GFX_TILE) begin
        build_tiles(bm);
      end else begin
        foreach (line_buf[i]) line_buf[i] = 0;
        for (int unsigned i = 0; i < BM_PIXELS; i++) begin
          if (cfg.gfx_mode == GFX_BM1) begin
            c = vram(BM_COLOR_BASE + (bm >> 3) * 40 + (i >> 3));
            b = vram(bm * 40 + (i >> 3));
            line_buf[i] = 8'('h10 | (((b >> (7 - (i & 7))) & 1) ? (c >> 4) : (c & 'hF)));
          end else if (cfg.gfx_mode == GFX_BM4) begin
            c = vram(bm * 80 + (i >> 2));
            line_buf[i] = 8'('h10 | ((i & 2) ? (c & 'hF) : (c >> 4)));
          end
        end
      end
      if (cfg.sprite_enable) draw_sprites(bm);
    endfunction

    function int unsigned text_pix(int unsigned x, int unsigned pos, bit vact);
      int unsigned addr, pix, chr, c, b;
      addr = 0;
      pix = x;
      if (vact && pos < ACTIVE_WIDTH) begin
        if (cfg.eighty_columns) begin
          addr = ((cur_line - 16) >> 3) * 80 + ((x - 32) >> 3);
        end else begin
          addr = ((cur_line - 16) >> 3) * 40 + (((x >> 1) - 16) >> 3);
          pix = x >> 1;
        end
      end else if (cfg.remap_border) begin
        addr = cfg.eighty_columns ? BORDER_CHAR_80 : BORDER_CHAR_40;
      end
      addr &= 'h7FF;
      chr = screen_ram[addr];
      c = color_ram[addr];
      b = char_ram[(chr * 8 + (cur_line & 7)) & 'h7FF];
      return ((b >> (7 - (pix & 7))) & 1) ? (c >> 4) : (c & 'hF);
    endfunction

    // One accepted input beat.
    function void note_beat(logic [1:0] req, logic [3:0] sel, logic [13:0] a,
                            logic [15:0] d, logic [8:0] ln, logic [9:0] x);
      int unsigned pos, txt, g, c;
      bit vact, act;
      c = 0;
      case (req)
        REQ_WRITE: begin
          if (sel == MEM_VIDEO) video_ram[a] = d[7:0];
          else if (sel <= MEM_CHAR && a < 2048) begin
            if (sel == MEM_SCREEN) screen_ram[a] = d[7:0];
            else if (sel == MEM_COLOR) color_ram[a] = d[7:0];
            else char_ram[a] = d[7:0];
          end else if (sel >= MEM_PALETTE && sel <= MEM_SPR_ATTR && a < 64) begin
            case (sel)
              MEM_PALETTE:  palette[a] = d;
              MEM_SPR_X:    spr_x[a] = d[8:0];
              MEM_SPR_Y:    spr_y[a] = d[7:0];
              MEM_SPR_TILE: spr_tile[a] = d[8:0];
              default:      spr_flags[a] = d[7:0];
            endcase
          end
        end
        REQ_LINE: begin
          cur_line = ln;
          in_frame = ln < FRAME_LINES;
          if (in_frame && ln >= ACTIVE_FIRST && ln < ACTIVE_END) build_line(ln);
        end
        REQ_PIXEL: begin
          if (in_frame && x < LINE_PIXELS) begin
            vact = cur_line >= ACTIVE_FIRST && cur_line < ACTIVE_END;
            pos = (1024 - TEXT_X_OFFSET + x) & 1023;
            act = vact && pos < ACTIVE_WIDTH;
            txt = text_pix(x, pos, vact);
            if (!act) begin
              if (cfg.text_enable) c = txt;
            end else begin
              g = line_buf[(pos >> 1) & 511];
              if (cfg.text_enable) c = txt;
              if (!cfg.text_enable || cfg.text_over_gfx || (g & 'hF) != 0) c = g;
              if (cfg.text_enable && cfg.text_over_gfx && txt != 0) c = txt;
            end
            expected_colors.push_back(palette[c & 'h3F]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_color(logic [15:0] got);
      bit [15:0] exp_c;
      if (expected_colors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel beat: color %h", got);
        return;
      end
      exp_c = expected_colors.pop_front();
      if (got !== exp_c) begin
        errors++;
        if (errors <= 10) $display("pixel_color mismatch: expected %h, got %h", exp_c, got);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 3000;
  // stimulus stays on lines 16 and 17 of the active area, so only these
  // parts of the stores are ever read
  localparam int TEXT_SLOTS = 82;
  localparam int VRAM_USED = 160;
  localparam int SPR_USED = 16;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [5:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb = new();
  bit tx_gaps = 0, rx_gaps = 0, hold_req = 0;
  int cycles = 0;

  video_line_renderer_core i_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_beat(s_tuser[1:0], s_tuser[5:2], s_tdata[13:0], s_tdata[29:14],
                   s_tdata[38:30], s_tdata[48:39]);
    if (!rst && m_tvalid && m_tready) sb.check_color(m_tdata);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 0;
        repeat (400) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Text cells of the first character row, then the two border cells.
  function automatic logic [13:0] text_slot(int i);
    if (i == 80) return 14'(BORDER_CHAR_40);
    if (i == 81) return 14'(BORDER_CHAR_80);
    return 14'(i);
  endfunction

  // Tile map entries keep tile numbers at 0..3 so patterns stay in the loaded area.
  function automatic logic [15:0] video_data(logic [13:0] a);
    logic [15:0] d;
    d = 16'($urandom);
    if (a < 14'd128) begin
      if (a[0]) d[0] = 1'b0;
      else d = 16'($urandom_range(0, 3));
    end
    return d;
  endfunction

  function automatic logic [8:0] pick_line();
    if ($urandom_range(0, 9) != 0) return 9'($urandom_range(16, 17));
    // border-only and out-of-frame lines
    return ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 15)) :
                                         9'($urandom_range(216, 511));
  endfunction

  task automatic send(logic [1:0] rq, logic [3:0] sel, logic [13:0] a, logic [15:0] d,
                      logic [8:0] ln, logic [9:0] x);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, x, ln, d, a};
    s_tuser <= {sel, rq};
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic mem_write(logic [3:0] sel, logic [13:0] a, logic [15:0] d);
    send(REQ_WRITE, sel, a, d, 9'($urandom), 10'($urandom));
  endtask

  task automatic start_line(logic [8:0] ln);
    send(REQ_LINE, 4'($urandom), 14'($urandom), 16'($urandom), ln, 10'($urandom));
  endtask

  task automatic pixel(logic [9:0] x);
    send(REQ_PIXEL, 4'($urandom), 14'($urandom), 16'($urandom), 9'($urandom), x);
  endtask

  task automatic idle_wait();
    s_tvalid <= 0;
    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_GFX_MODE:      sb.cfg.gfx_mode = v[1:0];
      REG_TEXT_ENABLE:   sb.cfg.text_enable = v[0];
      REG_TEXT_OVER_GFX: sb.cfg.text_over_gfx = v[0];
      REG_EIGHTY_COLS:   sb.cfg.eighty_columns = v[0];
      REG_REMAP_BORDER:  sb.cfg.remap_border = v[0];
      REG_SPRITE_ENABLE: sb.cfg.sprite_enable = v[0];
      REG_SCROLL_X:      sb.cfg.scroll_x = v[8:0];
      default:           sb.cfg.scroll_y = v[7:0];
    endcase
  endtask

  task automatic set_regs(logic [1:0] g, bit te, bit tog, bit e80, bit rb, bit se,
                          logic [8:0] sx, logic [7:0] sy);
    reg_write(REG_GFX_MODE, 32'(g));
    reg_write(REG_TEXT_ENABLE, 32'(te));
    reg_write(REG_TEXT_OVER_GFX, 32'(tog));
    reg_write(REG_EIGHTY_COLS, 32'(e80));
    reg_write(REG_REMAP_BORDER, 32'(rb));
    reg_write(REG_SPRITE_ENABLE, 32'(se));
    reg_write(REG_SCROLL_X, 32'(sx));
    reg_write(REG_SCROLL_Y, 32'(sy));
  endtask

  task automatic random_beat();
    int r;
    logic [3:0] sel;
    logic [13:0] a;
    logic [15:0] d;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      pixel(($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) :
                                           10'($urandom_range(0, 703)));
    end else if (r < 96) begin
      sel = 4'($urandom_range(0, 8));
      case (sel)
        MEM_SCREEN: begin
          a = text_slot($urandom_range(0, TEXT_SLOTS - 1));
          d = 16'($urandom_range(0, 7));
        end
        MEM_COLOR: begin
          a = text_slot($urandom_range(0, TEXT_SLOTS - 1));
          d = 16'($urandom);
        end
        MEM_VIDEO: begin
          a = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, VRAM_USED - 1));
          d = video_data(a);
        end
        MEM_SPR_TILE: begin
          a = 14'($urandom_range(0, 63));
          d = 16'($urandom_range(0, 3));
        end
        MEM_SPR_ATTR: begin
          a = 14'($urandom_range(0, 63));
          d = 16'($urandom);
          if (a >= 14'(SPR_USED)) d[7] = 1'b0;
        end
        default: begin
          a = 14'($urandom_range(0, 2047)) & ((sel >= MEM_PALETTE) ? 14'h3F : 14'h7FF);
          d = 16'($urandom);
        end
      endcase
      mem_write(sel, a, d);
    end else if (r < 98) begin
      // addresses out of range of every store but video RAM, and unknown selects
      mem_write(4'($urandom_range(0, 15)), 14'($urandom_range(2048, 16383)), 16'($urandom));
    end else begin
      send(2'd3, 4'($urandom), 14'($urandom), 16'($urandom), 9'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    logic [8:0] ln;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // load every entry that the stimulus below can read
    for (int i = 0; i < TEXT_SLOTS; i++) begin
      mem_write(MEM_SCREEN, text_slot(i), 16'($urandom_range(0, 7)));
      mem_write(MEM_COLOR, text_slot(i), 16'($urandom));
    end
    for (int i = 0; i < 64; i++) mem_write(MEM_CHAR, 14'(i), 16'($urandom));
    for (int i = 0; i < VRAM_USED; i++) mem_write(MEM_VIDEO, 14'(i), video_data(14'(i)));
    for (int i = 0; i < TEXT_COLS_40; i++)
      mem_write(MEM_VIDEO, 14'(BM_COLOR_BASE + i), 16'($urandom));
    for (int i = 0; i < 64; i++) mem_write(MEM_PALETTE, 14'(i), 16'($urandom));
    for (int i = 0; i < SPR_USED; i++) begin
      mem_write(MEM_SPR_X, 14'(i), 16'($urandom));
      mem_write(MEM_SPR_Y, 14'(i), 16'(($urandom_range(0, 31) + 240) & 255));
      mem_write(MEM_SPR_TILE, 14'(i), 16'($urandom_range(0, 3)));
      mem_write(MEM_SPR_ATTR, 14'(i), 16'($urandom));
    end
    // blank build so every line buffer entry holds a known value
    start_line(9'd16);
    idle_wait();

    // directed: line and pixel extremes, frame edges, ignored beats
    set_regs(GFX_TILE, 1, 1, 0, 1, 1, 9'd511, 8'd6);
    start_line(9'd16);
    pixel(10'd0); pixel(10'd31); pixel(10'd32); pixel(10'd671); pixel(10'd672);
    pixel(10'd703); pixel(10'd704);
    pixel(10'd1023);
    start_line(9'd17);
    pixel(10'd32); pixel(10'd671);
    start_line(9'd216);
    pixel(10'd300);
    start_line(9'd239);
    pixel(10'd100);
    start_line(9'd240);
    pixel(10'd100);
    start_line(9'd511);
    pixel(10'd5);
    mem_write(MEM_SCREEN, 14'd2048, 16'hFFFF);
    mem_write(MEM_PALETTE, 14'd64, 16'hFFFF);
    mem_write(4'd9, 14'd1, 16'h1234);
    mem_write(4'd15, 14'h3FFF, 16'hFFFF);
    send(2'd3, 4'd0, 14'd0, 16'hFFFF, 9'd0, 10'd0);
    start_line(9'd0);
    pixel(10'd703);
    idle_wait();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(GFX_TILE, 1, 1, 0, 1, 1, 9'd511, 8'd6);
        1: set_regs(GFX_BM1, 1, 0, 1, 0, 1, 9'd0, 8'd0);
        2: set_regs(GFX_BM4, 1, 1, 1, 1, 0, 9'd0, 8'd128);
        3: set_regs(GFX_NONE, 0, 0, 0, 0, 0, 9'd0, 8'd0);
        4: set_regs(GFX_TILE, 1, 0, 0, 1, 1, 9'($urandom), 8'($urandom_range(0, 6)));
        default: set_regs(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom), 9'($urandom),
                          8'($urandom_range(0, 6)));
      endcase
      tx_gaps = ph < 5;
      rx_gaps = ph < 5;
      for (int n = 0; n < 100; ) begin
        ln = pick_line();
        start_line(ln);
        n++;
        if (ph == 2 && n == 1) hold_req = 1;
        for (int k = $urandom_range(15, 35); k > 0; k--) begin
          random_beat();
          n++;
        end
      end
      idle_wait();
    end

    if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
